// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL modules of the byte ring buffer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BRB_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define BRB_NEVER(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define BRB_ASSERT(lbl, prop)
`define BRB_NEVER(lbl, expr)
`endif
`endif

// ----- rtl/brb_pkg.sv -----
// Package with the constants, codes and types of the byte ring buffer.
package brb_pkg;
	localparam int DEPTH      = 256;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CNT_W      = PTR_W + 1;
	localparam int MAX_BURST  = 8;
	localparam int LEN_W      = 4;
	localparam int BIDX_W     = 3;
	localparam int DATA_W     = 64;
	localparam int PADDR_W    = 3;

	localparam logic [PADDR_W-1:0] ADDR_CAP = 3'd0;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MOVE,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic done_zero;
		logic last;
	} stat_t;
endpackage

// ----- rtl/brb_datapath.sv -----
// Datapath of the byte ring buffer: byte store, pointers, fill count and result registers.
`include "assert_macros.svh"
module brb_datapath
	import brb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [CNT_W-1:0]    cap,
	input  logic                cfg_clr,
	input  cmd_t                cmd,
	output stat_t               st,
	input  logic                action,
	input  logic [LEN_W-1:0]    req_len,
	input  logic [DATA_W-1:0]   data_in,
	output logic [1:0]          status,
	output logic [LEN_W-1:0]    done_len,
	output logic [DATA_W-1:0]   data_out,
	output logic [CNT_W-1:0]    used_count
);
	logic [7:0]        mem_q [DEPTH];
	logic [7:0]        rdata_q;
	logic [PTR_W-1:0]  rptr_q, wptr_q;
	logic [CNT_W-1:0]  used_q;
	logic              act_q;
	logic [DATA_W-1:0] din_q, dout_q;
	logic [LEN_W-1:0]  done_q;
	logic [1:0]        status_q;
	logic [BIDX_W-1:0] cnt_q, cidx_q;
	logic              rd_pend_q;

	logic [CNT_W-1:0]  cap_eff, space, avail, ptr_inc, used_next;
	logic [LEN_W-1:0]  len_c, done_c;
	logic [1:0]        status_c;
	logic [PTR_W-1:0]  ptr_cur, ptr_next, addr;

	always_comb begin
		if (cap == '0) begin
			cap_eff = CNT_W'(1);
		end else if (cap > CNT_W'(DEPTH)) begin
			cap_eff = CNT_W'(DEPTH);
		end else begin
			cap_eff = cap;
		end
		space = cap_eff - used_q;
		len_c = (req_len > LEN_W'(MAX_BURST)) ? LEN_W'(MAX_BURST) : req_len;
		avail = (action == ACT_READ) ? used_q : space;
		if (avail == '0) begin
			done_c   = '0;
			status_c = (action == ACT_READ) ? STAT_EMPTY : STAT_FULL;
		end else begin
			done_c   = ({{(CNT_W-LEN_W){1'b0}}, len_c} < avail) ? len_c : avail[LEN_W-1:0];
			status_c = STAT_OK;
		end
		addr     = (act_q == ACT_READ) ? rptr_q : wptr_q;
		ptr_cur  = addr;
		ptr_inc  = {1'b0, ptr_cur} + CNT_W'(1);
		ptr_next = (ptr_inc >= cap_eff) ? '0 : ptr_inc[PTR_W-1:0];
		if (act_q == ACT_READ) begin
			used_next = used_q - {{(CNT_W-LEN_W){1'b0}}, done_q};
		end else begin
			used_next = used_q + {{(CNT_W-LEN_W){1'b0}}, done_q};
		end
		st.done_zero = (done_q == '0);
		st.last      = (({1'b0, cnt_q} + LEN_W'(1)) == done_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			if (act_q == ACT_WRITE) begin
				mem_q[addr] <= din_q[{cnt_q, 3'b000} +: 8];
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rptr_q    <= '0;
			wptr_q    <= '0;
			used_q    <= '0;
			rd_pend_q <= 1'b0;
			done_q    <= '0;
			status_q  <= STAT_OK;
			cnt_q     <= '0;
		end else begin
			rd_pend_q <= cmd.step && (act_q == ACT_READ);
			if (cfg_clr) begin
				rptr_q <= '0;
				wptr_q <= '0;
				used_q <= '0;
			end else begin
				if (cmd.load) begin
					done_q   <= done_c;
					status_q <= status_c;
					cnt_q    <= '0;
				end
				if (cmd.step) begin
					cnt_q <= cnt_q + BIDX_W'(1);
					if (act_q == ACT_READ) begin
						rptr_q <= ptr_next;
					end else begin
						wptr_q <= ptr_next;
					end
				end
				if (cmd.finish) begin
					used_q <= used_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action;
			din_q  <= data_in;
			dout_q <= '0;
		end else if (rd_pend_q) begin
			dout_q[{cidx_q, 3'b000} +: 8] <= rdata_q;
		end
		if (cmd.step) begin
			cidx_q <= cnt_q;
		end
		if (cmd.finish) begin
			status     <= status_q;
			done_len   <= done_q;
			data_out   <= dout_q;
			used_count <= used_next;
		end
	end

	`BRB_ASSERT(a_used_in_range, used_q <= cap_eff)
	`BRB_ASSERT(a_step_in_burst, cmd.step |-> ({1'b0, cnt_q} < done_q))
	`BRB_ASSERT(a_error_moves_none, (status_q != STAT_OK) |-> (done_q == '0))
endmodule

// ----- rtl/brb_ctrl.sv -----
// Controller of the byte ring buffer: request sequencing and the output handshake.
`include "assert_macros.svh"
module brb_ctrl
	import brb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	output cmd_t  cmd,
	input  stat_t st
);
	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MOVE;
				end
			end
			ST_MOVE: begin
				if (st.done_zero) begin
					state_d = ST_FINISH;
				end else begin
					cmd.step = 1'b1;
					if (st.last) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	`BRB_ASSERT(a_finish_shows_result, cmd.finish |=> out_valid_q)
	`BRB_ASSERT(a_drain_then_finish, (state_q == ST_DRAIN) |=> (state_q == ST_FINISH))
	`BRB_NEVER(a_finish_over_waiting, cmd.finish && out_valid_q && !out_ready)
endmodule

// ----- rtl/byte_ring_buffer_burst_unit.sv -----
// Top level of the byte ring buffer: register port, controller and datapath.
//
//   port     direction  payload                                handshake
//   in       sink       action, req_len, data_in               in_valid / in_ready
//   out      source     status, done_len, data_out, used_count out_valid / out_ready
//   cfg      APB        capacity_in_use at address 0           psel / penable / pready
//
// A request runs idle, move, drain, finish; with nothing to move it skips drain.
// The byte store has a single port and moves one byte per cycle.
// Reset empties the ring and sets the capacity to the full store depth.
// A finished result waits in the output register while the next request is taken.
// Any write of the capacity register empties the ring.
`include "assert_macros.svh"
module byte_ring_buffer_burst_unit
	import brb_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                action,
	input  logic [LEN_W-1:0]    req_len,
	input  logic [DATA_W-1:0]   data_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [LEN_W-1:0]    done_len,
	output logic [DATA_W-1:0]   data_out,
	output logic [CNT_W-1:0]    used_count
);
	logic [CNT_W-1:0] cap_q;
	logic             cfg_wr;
	cmd_t             cmd;
	stat_t            st;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_CAP);
	assign prdata = (paddr == ADDR_CAP) ? {{(32-CNT_W){1'b0}}, cap_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CNT_W'(DEPTH);
		end else if (cfg_wr) begin
			cap_q <= pwdata[CNT_W-1:0];
		end
	end

	brb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.st        (st)
	);

	brb_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cap        (cap_q),
		.cfg_clr    (cfg_wr),
		.cmd        (cmd),
		.st         (st),
		.action     (action),
		.req_len    (req_len),
		.data_in    (data_in),
		.status     (status),
		.done_len   (done_len),
		.data_out   (data_out),
		.used_count (used_count)
	);

	`BRB_ASSERT(a_ready_means_idle, in_ready |-> !(cmd.step || cmd.finish))
	`BRB_NEVER(a_cap_write_while_busy, cfg_wr && cmd.step)
endmodule

// ----- bench/byte_ring_buffer_burst_unit_tb.sv -----
// Testbench for the byte ring buffer burst unit: directed and random requests checked against a ring predictor.
`timescale 1ns / 100ps

module byte_ring_buffer_burst_unit_tb;
	import brb_pkg::*;

	typedef struct packed {
		logic              action;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] data;
	} ring_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [LEN_W-1:0]  done_len;
		logic [DATA_W-1:0] data;
		logic [CNT_W-1:0]  used;
	} ring_reply_t;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               action = 1'b0;
	logic [LEN_W-1:0]   req_len = '0;
	logic [DATA_W-1:0]  data_in = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic [LEN_W-1:0]   done_len;
	logic [DATA_W-1:0]  data_out;
	logic [CNT_W-1:0]   used_count;

	byte_ring_buffer_burst_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .req_len(req_len), .data_in(data_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .done_len(done_len), .data_out(data_out),
		.used_count(used_count)
	);

	// Ring predictor state.
	logic [7:0] ring_bytes [DEPTH];
	int ring_cap = DEPTH;
	int rd_idx = 0;
	int wr_idx = 0;
	bit ring_full = 1'b0;

	ring_req_t   queued_requests [$];
	ring_reply_t predicted_replies [$];
	ring_req_t   cur_req;
	int requests_queued = 0;
	int requests_taken = 0;
	int replies_seen = 0;
	int send_gap = 0;
	int recv_stall = 0;
	int hold_left = 0;
	int fail_count = 0;
	int cycle_count = 0;
	bit no_gaps = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int held_bytes();
		if (wr_idx == rd_idx)
			return ring_full ? ring_cap : 0;
		if (wr_idx > rd_idx)
			return wr_idx - rd_idx;
		return ring_cap - (rd_idx - wr_idx);
	endfunction

	function automatic ring_reply_t apply_ring_request(ring_req_t rq);
		ring_reply_t r;
		logic [LEN_W-1:0] len;
		int avail;
		int n;
		r = '0;
		r.status = STAT_OK;
		len = (rq.len > MAX_BURST) ? LEN_W'(MAX_BURST) : rq.len;
		if (rq.action == ACT_WRITE) begin
			avail = ring_cap - held_bytes();
			if (avail == 0) begin
				r.status = STAT_FULL;
			end else begin
				n = (len < avail) ? len : avail;
				for (int k = 0; k < n; k++) begin
					ring_bytes[wr_idx] = rq.data[8*k +: 8];
					wr_idx = (wr_idx + 1 >= ring_cap) ? 0 : wr_idx + 1;
				end
				if (n != 0 && wr_idx == rd_idx)
					ring_full = 1'b1;
				r.done_len = LEN_W'(n);
			end
		end else begin
			avail = held_bytes();
			if (avail == 0) begin
				r.status = STAT_EMPTY;
			end else begin
				n = (len < avail) ? len : avail;
				for (int k = 0; k < n; k++) begin
					r.data[8*k +: 8] = ring_bytes[rd_idx];
					rd_idx = (rd_idx + 1 >= ring_cap) ? 0 : rd_idx + 1;
				end
				if (n != 0)
					ring_full = 1'b0;
				r.done_len = LEN_W'(n);
			end
		end
		r.used = CNT_W'(held_bytes());
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic queue_request(input logic act, input int len, input logic [DATA_W-1:0] d);
		ring_req_t rq;
		rq.action = act;
		rq.len = LEN_W'(len);
		rq.data = d;
		queued_requests.push_back(rq);
		requests_queued++;
	endtask

	task automatic queue_random(input int count, input int write_pct);
		int r;
		int len;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 19);
			if (r == 0)
				len = 0;
			else if (r < 18)
				len = $urandom_range(1, MAX_BURST);
			else
				len = $urandom_range(MAX_BURST + 1, 15);
			queue_request(($urandom_range(0, 99) < write_pct) ? ACT_WRITE : ACT_READ, len,
				{$urandom, $urandom});
		end
	endtask

	// Returns once every queued request has been taken and answered, plus a margin.
	task automatic wait_quiet();
		while (requests_taken != requests_queued || predicted_replies.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [31:0] value);
		int c;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_CAP;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		c = int'(value & 32'h1FF);
		if (c == 0)
			c = 1;
		if (c > DEPTH)
			c = DEPTH;
		ring_cap = c;
		rd_idx = 0;
		wr_idx = 0;
		ring_full = 1'b0;
	endtask

	// Request driver.
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			predicted_replies.push_back(apply_ring_request(cur_req));
			requests_taken++;
		end
		if (!in_valid || in_ready) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (queued_requests.size() > 0) begin
				cur_req = queued_requests.pop_front();
				in_valid <= 1'b1;
				action <= cur_req.action;
				req_len <= cur_req.len;
				data_in <= cur_req.data;
				send_gap = pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Reply monitor and receiver stalls.
	always @(posedge clk) begin
		ring_reply_t want;
		if (out_valid && out_ready) begin
			if (predicted_replies.size() == 0) begin
				$error("reply with no request outstanding");
				fail_count++;
			end else begin
				want = predicted_replies.pop_front();
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
				if (done_len !== want.done_len) begin
					$error("done_len: expected %0d, got %0d", want.done_len, done_len);
					fail_count++;
				end
				if (data_out !== want.data) begin
					$error("data_out: expected %h, got %h", want.data, data_out);
					fail_count++;
				end
				if (used_count !== want.used) begin
					$error("used_count: expected %0d, got %0d", want.used, used_count);
					fail_count++;
				end
			end
			replies_seen++;
			if (replies_seen == 150 || replies_seen == 700)
				hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (recv_stall > 0) begin
			recv_stall--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			recv_stall = pick_gap();
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int caps [10];
		caps = '{256, 2, 7, 1, 511, 13, 64, 0, 3, 300};
		caps[7] = $urandom_range(1, DEPTH);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		queue_request(ACT_READ, 0, '0);
		queue_request(ACT_READ, 8, '0);
		queue_request(ACT_WRITE, 0, {$urandom, $urandom});
		queue_request(ACT_WRITE, 8, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_request(ACT_WRITE, 15, {$urandom, $urandom});
		queue_request(ACT_READ, 0, '0);
		queue_request(ACT_READ, 15, '0);
		queue_request(ACT_READ, 4, '0);
		queue_request(ACT_READ, 9, '0);
		queue_request(ACT_READ, 1, '0);
		wait_quiet();

		write_capacity(32'd0);
		queue_request(ACT_WRITE, 3, '0);
		queue_request(ACT_WRITE, 0, '0);
		queue_request(ACT_WRITE, 8, {$urandom, $urandom});
		queue_request(ACT_READ, 0, '0);
		queue_request(ACT_READ, 8, '0);
		queue_request(ACT_READ, 2, '0);
		wait_quiet();

		write_capacity(32'hFFFF_FE05);
		queue_request(ACT_WRITE, 3, {$urandom, $urandom});
		queue_request(ACT_WRITE, 4, {$urandom, $urandom});
		queue_request(ACT_READ, 2, '0);
		queue_request(ACT_WRITE, 8, {$urandom, $urandom});
		queue_request(ACT_READ, 15, '0);
		queue_request(ACT_READ, 0, '0);
		wait_quiet();

		for (int p = 0; p < 10; p++) begin
			write_capacity(32'(caps[p]));
			no_gaps = (p % 3 == 2);
			queue_random(62, 70);
			queue_random(62, 35);
			wait_quiet();
		end

		repeat (20) @(posedge clk);
		if (predicted_replies.size() != 0) begin
			$error("%0d replies never arrived", predicted_replies.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

// ----- byte_ring_buffer_burst_unit.f -----
+incdir+rtl
rtl/brb_pkg.sv
rtl/brb_datapath.sv
rtl/brb_ctrl.sv
rtl/byte_ring_buffer_burst_unit.sv
bench/byte_ring_buffer_burst_unit_tb.sv
